[rtl/ip_address_text_parser_assert.svh]
// Assertion macros for the address text parser.
`ifndef IP_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define IATP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IATP_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IATP_ASSERT_CLK(label, clk, rst, prop, msg)
`define IATP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[rtl/iatp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iatp_pkg
// Types and constants shared by the address text parser modules.
// ---------------------------------------------------------------------------
package iatp_pkg;

   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [9:0] OctetMax  = 10'd255;

   localparam logic [1:0] ErrNone = 2'd0;
   localparam logic [1:0] ErrV4   = 2'd1;
   localparam logic [1:0] ErrV6   = 2'd2;

   typedef enum logic [2:0] {
      PH_START, PH_LEAD, PH_GAP, PH_GROUP, PH_SEP, PH_TAIL
   } phase_type;

   typedef struct packed {
      logic [1:0]  octet_index;
      logic [9:0]  value;
      logic [1:0]  digit_count;
      logic        leading_zero;
      logic [31:0] bytes;
      logic        failed;
   } quad_type;

   typedef struct packed {
      logic [7:0][15:0] words;
      logic [3:0]       count;
      logic [3:0]       gap_pos;
      logic             gap_seen;
      logic [15:0]      hex_value;
      logic [2:0]       digit_count;
      logic [9:0]       dec_value;
      logic             all_dec;
      phase_type        phase;
      logic             failed;
      logic             colon_seen;
   } hex_type;

   typedef struct packed {
      logic        accepted;
      logic        is_v6;
      logic [1:0]  error_kind;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } result_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      // Bit 4 marks a valid hex digit.
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic quad_type quad_reset();
      quad_type q;
      q = '0;
      return q;
   endfunction

   function automatic hex_type hex_reset();
      hex_type h;
      h = '0;
      h.all_dec = 1'b1;
      h.phase = PH_START;
      return h;
   endfunction

   // Close the current octet: bit 32 valid, low bits the updated byte word.
   function automatic logic [32:0] quad_close(input quad_type q);
      logic [31:0] b;
      logic ok;
      b = q.bytes;
      ok = q.digit_count != 2'd0 && q.value <= OctetMax &&
           !(q.leading_zero && q.digit_count > 2'd1);
      b[8*(3-q.octet_index) +: 8] = b[8*(3-q.octet_index) +: 8] | q.value[7:0];
      return {ok, b};
   endfunction

endpackage

[rtl/iatp_step.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iatp_step
// Next-state logic for both recognizers for one character.
// ---------------------------------------------------------------------------
module iatp_step import iatp_pkg::*; (
   input  quad_type   quad_cur,
   input  hex_type    hex_cur,
   input  logic [7:0] char_code,
   output quad_type   quad_nxt,
   output hex_type    hex_nxt
);
   logic [4:0]  hd;
   logic [32:0] qc;
   logic [9:0]  cdig;
   quad_type    qa;

   assign hd   = hex_digit(char_code);
   assign cdig = {6'd0, char_code[3:0]};

   always_comb begin
      hex_nxt = hex_cur;
      qa = quad_cur;
      if (char_code == CharColon) hex_nxt.colon_seen = 1'b1;
      if (!hex_cur.failed) begin
         case (hex_cur.phase)
            PH_START: begin
               if (char_code == CharColon) hex_nxt.phase = PH_LEAD;
               else if (hd[4]) begin
                  hex_nxt.hex_value = {12'd0, hd[3:0]};
                  hex_nxt.digit_count = 3'd1;
                  hex_nxt.all_dec = is_dec(char_code);
                  hex_nxt.dec_value = is_dec(char_code) ? cdig : 10'd0;
                  hex_nxt.phase = PH_GROUP;
               end else hex_nxt.failed = 1'b1;
            end
            PH_LEAD: begin
               if (char_code == CharColon) begin
                  hex_nxt.gap_seen = 1'b1;
                  hex_nxt.gap_pos = 4'd0;
                  hex_nxt.phase = PH_GAP;
               end else hex_nxt.failed = 1'b1;
            end
            PH_GAP, PH_SEP: begin
               if (hd[4]) begin
                  if (hex_cur.count >= 4'd8) hex_nxt.failed = 1'b1;
                  else begin
                     hex_nxt.hex_value = {12'd0, hd[3:0]};
                     hex_nxt.digit_count = 3'd1;
                     hex_nxt.all_dec = is_dec(char_code);
                     hex_nxt.dec_value = is_dec(char_code) ? cdig : 10'd0;
                     hex_nxt.phase = PH_GROUP;
                  end
               end else if (char_code == CharColon && hex_cur.phase == PH_SEP &&
                            !hex_cur.gap_seen) begin
                  hex_nxt.gap_seen = 1'b1;
                  hex_nxt.gap_pos = hex_cur.count;
                  hex_nxt.phase = PH_GAP;
               end else hex_nxt.failed = 1'b1;
            end
            PH_GROUP: begin
               if (hd[4]) begin
                  if (hex_cur.digit_count >= 3'd4) hex_nxt.failed = 1'b1;
                  else begin
                     hex_nxt.hex_value = {hex_cur.hex_value[11:0], hd[3:0]};
                     if (is_dec(char_code)) begin
                        if (hex_cur.digit_count < 3'd3)
                           hex_nxt.dec_value = 10'(hex_cur.dec_value * 10'd10 + cdig);
                     end else hex_nxt.all_dec = 1'b0;
                     hex_nxt.digit_count = hex_cur.digit_count + 3'd1;
                  end
               end else if (char_code == CharColon) begin
                  hex_nxt.words[hex_cur.count[2:0]] = hex_cur.hex_value;
                  hex_nxt.count = hex_cur.count + 4'd1;
                  hex_nxt.phase = PH_SEP;
               end else if (char_code == CharDot && hex_cur.all_dec &&
                            hex_cur.digit_count <= 3'd3 && hex_cur.count <= 4'd6 &&
                            hex_cur.colon_seen) begin
                  qa.octet_index = 2'd0;
                  qa.value = hex_cur.dec_value;
                  qa.digit_count = hex_cur.digit_count[1:0];
                  qa.leading_zero = hex_cur.digit_count > 3'd1 &&
                     hex_cur.dec_value < ((hex_cur.digit_count == 3'd2) ? 10'd10 : 10'd100);
                  qa.bytes = '0;
                  qa.failed = 1'b0;
                  hex_nxt.phase = PH_TAIL;
               end else hex_nxt.failed = 1'b1;
            end
            PH_TAIL: ;
            default: hex_nxt.failed = 1'b1;
         endcase
      end
   end

   assign qc = quad_close(qa);

   always_comb begin
      quad_nxt = qa;
      if (!qa.failed) begin
         if (is_dec(char_code)) begin
            if (qa.digit_count == 2'd3) quad_nxt.failed = 1'b1;
            else begin
               if (qa.digit_count == 2'd0) quad_nxt.leading_zero = char_code == CharZero;
               quad_nxt.value = 10'(qa.value * 10'd10 + cdig);
               quad_nxt.digit_count = qa.digit_count + 2'd1;
            end
         end else if (char_code == CharDot) begin
            if (qa.octet_index == 2'd3 || !qc[32]) quad_nxt.failed = 1'b1;
            else begin
               quad_nxt.bytes = qc[31:0];
               quad_nxt.octet_index = qa.octet_index + 2'd1;
               quad_nxt.value = '0;
               quad_nxt.digit_count = '0;
               quad_nxt.leading_zero = 1'b0;
            end
         end else quad_nxt.failed = 1'b1;
      end
   end
endmodule

[rtl/iatp_finish.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iatp_finish
// Builds the result from the recognizer state after the last character.
// ---------------------------------------------------------------------------
module iatp_finish import iatp_pkg::*; (
   input  quad_type   quad_fin,
   input  hex_type    hex_fin,
   output result_type result
);
   logic [32:0]      qc;
   logic [7:0][15:0] w;
   logic [3:0]       cnt;
   logic             hfail, v4_ok, v6_ok;
   logic [3:0]       fill;
   logic [3:0]       src;
   logic [15:0]      outw [8];

   assign qc = quad_close(quad_fin);

   always_comb begin
      w = hex_fin.words;
      cnt = hex_fin.count;
      hfail = hex_fin.failed;
      v4_ok = 1'b0;
      if (hex_fin.phase == PH_TAIL) begin
         if (!hex_fin.failed && !quad_fin.failed && quad_fin.octet_index == 2'd3 &&
             qc[32]) begin
            w[cnt[2:0]] = qc[31:16];
            w[3'(cnt + 4'd1)] = qc[15:0];
            cnt = cnt + 4'd2;
         end else hfail = 1'b1;
      end else begin
         v4_ok = !quad_fin.failed && quad_fin.octet_index == 2'd3 && qc[32];
         if (hex_fin.phase == PH_GROUP) begin
            w[cnt[2:0]] = hex_fin.hex_value;
            cnt = cnt + 4'd1;
         end else if (hex_fin.phase != PH_GAP) hfail = 1'b1;
      end
      v6_ok = !v4_ok && !hfail &&
              (hex_fin.gap_seen ? (cnt < 4'd8) : (cnt == 4'd8));
      fill = 4'd8 - cnt;
      for (int k = 0; k < 8; k++) begin
         src = 4'(k) - fill;
         if (!hex_fin.gap_seen || 4'(k) < hex_fin.gap_pos) outw[k] = w[k];
         else if (5'(k) >= 5'(hex_fin.gap_pos) + 5'(fill)) outw[k] = w[src[2:0]];
         else outw[k] = '0;
      end
      result = '0;
      if (v4_ok) begin
         result.accepted = 1'b1;
         result.addr_high = {qc[31:0], 32'd0};
      end else if (v6_ok) begin
         result.accepted = 1'b1;
         result.is_v6 = 1'b1;
         result.addr_high = {outw[0], outw[1], outw[2], outw[3]};
         result.addr_low  = {outw[4], outw[5], outw[6], outw[7]};
      end else result.error_kind = hex_fin.colon_seen ? ErrV6 : ErrV4;
   end
endmodule

[rtl/ip_address_text_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ip_address_text_parser
// Streams address text and reports an IPv4 or IPv6 address or an error.
// ---------------------------------------------------------------------------
// Usage: each request carries one character (req_char_code) and a flag
// (req_last_char) marking the final character of the string. An IPv4 and an
// IPv6 recognizer advance together on every character; their state lives in
// registers updated once per accepted request.
// Only the request with the last-character flag produces a response, with
// accepted, is_v6, error_kind and the 128-bit address split over
// rsp_addr_high and rsp_addr_low. After it both recognizers return to the
// start state, so the next request begins a new string.
// Throughput is one character per cycle while req_ready is high. The response
// appears in the cycle after the last character is accepted, held in a single
// output register. A request is taken while that register is empty or being
// drained in the same cycle, so a stalled receiver holds the response and
// back-pressures the sender only while the result is not taken.
// Reset clears the recognizer state and drops any pending response.
// ---------------------------------------------------------------------------
module ip_address_text_parser import iatp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_is_v6,
   output logic [1:0]  rsp_error_kind,
   output logic [63:0] rsp_addr_high,
   output logic [63:0] rsp_addr_low
);
`include "ip_address_text_parser_assert.svh"

   quad_type   quad_ff, quad_in, quad_step;
   hex_type    hex_ff, hex_in, hex_step;
   result_type res_ff, res_in, res_comb;
   logic       valid_ff, valid_in;
   logic       take;

   // The parser state registers act as the input register.
   iatp_step u_step (
      .quad_cur (quad_ff),
      .hex_cur  (hex_ff),
      .char_code(req_char_code),
      .quad_nxt (quad_step),
      .hex_nxt  (hex_step)
   );

   iatp_finish u_finish (
      .quad_fin(quad_step),
      .hex_fin (hex_step),
      .result  (res_comb)
   );

   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      quad_in  = quad_ff;
      hex_in   = hex_ff;
      res_in   = res_ff;
      valid_in = valid_ff && !rsp_ready;
      if (take) begin
         if (req_last_char) begin
            quad_in  = quad_reset();
            hex_in   = hex_reset();
            res_in   = res_comb;
            valid_in = 1'b1;
         end else begin
            quad_in = quad_step;
            hex_in  = hex_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_ff  <= quad_reset();
         hex_ff   <= hex_reset();
         valid_ff <= 1'b0;
      end else begin
         quad_ff  <= quad_in;
         hex_ff   <= hex_in;
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_accepted   = res_ff.accepted;
   assign rsp_is_v6      = res_ff.is_v6;
   assign rsp_error_kind = res_ff.error_kind;
   assign rsp_addr_high  = res_ff.addr_high;
   assign rsp_addr_low   = res_ff.addr_low;

   `IATP_ASSERT_CLK(a_resp_after_last, clock, reset,
      req_valid && req_ready && req_last_char |=> rsp_valid,
      "Last character did not produce a response.")
   `IATP_ASSERT_CLK(a_err_consistent, clock, reset,
      rsp_valid |-> (rsp_accepted == (rsp_error_kind == ErrNone)),
      "Accepted flag disagrees with error kind.")
   `IATP_ASSERT_CLK(a_v4_low_zero, clock, reset,
      rsp_valid && rsp_accepted && !rsp_is_v6 |-> rsp_addr_low == 64'd0,
      "IPv4 result has nonzero low word.")
   `IATP_ASSERT_RST(a_reset_clears, clock,
      reset |=> !rsp_valid,
      "Response valid right after reset.")
endmodule

[sim/ip_address_text_parser_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_parse_monitor
// Watches the parser's channels, predicts each response and compares it.
// ---------------------------------------------------------------------------
// Every accepted character steps a private model of both recognizers. A
// character marked last yields an expected response, which waits in a queue
// until the block delivers one. Fields are compared one by one.
// ---------------------------------------------------------------------------
module address_parse_monitor import iatp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic        rsp_is_v6,
   input  logic [1:0]  rsp_error_kind,
   input  logic [63:0] rsp_addr_high,
   input  logic [63:0] rsp_addr_low,
   output int          fail_count,
   output int          pending_count
);

   // Dotted-quad recognizer.
   logic [1:0]  oct_idx;
   logic [9:0]  oct_val;
   logic [1:0]  oct_digits;
   logic        oct_lz;
   logic [31:0] oct_bytes;
   logic        oct_bad;
   // IPv6 recognizer.
   logic [15:0] grp_words [8];
   logic [3:0]  grp_count;
   logic [3:0]  gap_at;
   logic        gap_found;
   logic [15:0] grp_hex;
   logic [2:0]  grp_digits;
   logic [9:0]  grp_dec;
   logic        grp_all_dec;
   phase_type   phase;
   logic        v6_bad;
   logic        colon_any;

   result_type  expected_results [$];

   function automatic bit is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic int nibble_of(input logic [7:0] c);
      if (is_digit(c)) return int'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
      return -1;
   endfunction

   task automatic clear_parser();
      oct_idx = '0; oct_val = '0; oct_digits = '0; oct_lz = 1'b0;
      oct_bytes = '0; oct_bad = 1'b0;
      for (int k = 0; k < 8; k++) grp_words[k] = '0;
      grp_count = '0; gap_at = '0; gap_found = 1'b0; grp_hex = '0;
      grp_digits = '0; grp_dec = '0; grp_all_dec = 1'b1; phase = PH_START;
      v6_bad = 1'b0; colon_any = 1'b0;
   endtask

   // Closes the current octet and merges its byte; returns 1 if it is valid.
   function automatic bit close_octet();
      if (oct_digits == 0 || oct_val > OctetMax) return 1'b0;
      if (oct_lz && oct_digits > 1) return 1'b0;
      oct_bytes = oct_bytes | (32'(oct_val[7:0]) << (8 * (3 - oct_idx)));
      return 1'b1;
   endfunction

   task automatic begin_group(input int d, input logic [7:0] c);
      grp_hex = 16'(d);
      grp_digits = 3'd1;
      grp_all_dec = is_digit(c);
      grp_dec = grp_all_dec ? 10'(d) : 10'd0;
      phase = PH_GROUP;
   endtask

   task automatic store_group();
      grp_words[grp_count[2:0]] = grp_hex;
      grp_count = grp_count + 4'd1;
   endtask

   task automatic step_v6(input logic [7:0] c);
      int d;
      d = nibble_of(c);
      if (v6_bad) return;
      case (phase)
         PH_START: begin
            if (c == CharColon) phase = PH_LEAD;
            else if (d >= 0) begin_group(d, c);
            else v6_bad = 1'b1;
         end
         PH_LEAD: begin
            if (c == CharColon) begin
               gap_found = 1'b1; gap_at = '0; phase = PH_GAP;
            end else v6_bad = 1'b1;
         end
         PH_GAP, PH_SEP: begin
            if (d >= 0) begin
               if (grp_count >= 8) v6_bad = 1'b1;
               else begin_group(d, c);
            end else if (c == CharColon && phase == PH_SEP && !gap_found) begin
               gap_found = 1'b1; gap_at = grp_count; phase = PH_GAP;
            end else v6_bad = 1'b1;
         end
         PH_GROUP: begin
            if (d >= 0) begin
               if (grp_digits >= 4) v6_bad = 1'b1;
               else begin
                  grp_hex = {grp_hex[11:0], 4'(d)};
                  if (is_digit(c)) begin
                     if (grp_digits < 3) grp_dec = 10'(grp_dec * 10 + d);
                  end else grp_all_dec = 1'b0;
                  grp_digits = grp_digits + 3'd1;
               end
            end else if (c == CharColon) begin
               store_group();
               phase = PH_SEP;
            end else if (c == CharDot && grp_all_dec && grp_digits <= 3 &&
                         grp_count <= 6 && colon_any) begin
               // The group read so far becomes the first octet of the tail.
               oct_idx = '0;
               oct_val = grp_dec;
               oct_digits = grp_digits[1:0];
               oct_lz = grp_digits > 1 && grp_dec < (grp_digits == 2 ? 10 : 100);
               oct_bytes = '0;
               oct_bad = 1'b0;
               phase = PH_TAIL;
            end else v6_bad = 1'b1;
         end
         PH_TAIL: ;
         default: v6_bad = 1'b1;
      endcase
   endtask

   task automatic step_v4(input logic [7:0] c);
      if (oct_bad) return;
      if (is_digit(c)) begin
         if (oct_digits >= 3) begin
            oct_bad = 1'b1;
            return;
         end
         if (oct_digits == 0) oct_lz = c == CharZero;
         oct_val = 10'(oct_val * 10 + (c - 8'h30));
         oct_digits = oct_digits + 2'd1;
      end else if (c == CharDot) begin
         if (oct_idx >= 3 || !close_octet()) begin
            oct_bad = 1'b1;
            return;
         end
         oct_idx = oct_idx + 2'd1;
         oct_val = '0; oct_digits = '0; oct_lz = 1'b0;
      end else oct_bad = 1'b1;
   endtask

   task automatic predict_char(input logic [7:0] c, input logic last);
      result_type r;
      bit v4_ok, v6_ok;
      logic [3:0] fill;
      logic [15:0] w;
      if (c == CharColon) colon_any = 1'b1;
      step_v6(c);
      step_v4(c);
      if (!last) return;
      v4_ok = 1'b0;
      v6_ok = 1'b0;
      if (phase == PH_TAIL) begin
         if (!v6_bad && !oct_bad && oct_idx == 3 && close_octet()) begin
            grp_words[grp_count[2:0]] = oct_bytes[31:16];
            grp_words[3'(grp_count + 1)] = oct_bytes[15:0];
            grp_count = grp_count + 4'd2;
         end else v6_bad = 1'b1;
      end else begin
         v4_ok = !oct_bad && oct_idx == 3 && close_octet();
         if (phase == PH_GROUP) store_group();
         else if (phase != PH_GAP) v6_bad = 1'b1;
      end
      if (!v4_ok && !v6_bad) v6_ok = gap_found ? grp_count < 8 : grp_count == 8;
      r = '0;
      if (v4_ok) begin
         r.accepted = 1'b1;
         r.addr_high = {oct_bytes, 32'd0};
      end else if (v6_ok) begin
         r.accepted = 1'b1;
         r.is_v6 = 1'b1;
         fill = 4'd8 - grp_count;
         for (int k = 0; k < 8; k++) begin
            w = '0;
            if (!gap_found || k < gap_at) w = grp_words[k];
            else if (k >= gap_at + fill) w = grp_words[3'(k - fill)];
            if (k < 4) r.addr_high = {r.addr_high[47:0], w};
            else r.addr_low = {r.addr_low[47:0], w};
         end
      end else begin
         r.error_kind = colon_any ? ErrV6 : ErrV4;
      end
      expected_results.push_back(r);
      clear_parser();
   endtask

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         // The response leaving now is older than any request taken now.
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with none expected");
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_accepted !== e.accepted) begin
                  $error("accepted: expected %0b, got %0b", e.accepted, rsp_accepted);
                  fail_count++;
               end
               if (rsp_is_v6 !== e.is_v6) begin
                  $error("is_v6: expected %0b, got %0b", e.is_v6, rsp_is_v6);
                  fail_count++;
               end
               if (rsp_error_kind !== e.error_kind) begin
                  $error("error_kind: expected %0d, got %0d", e.error_kind,
                         rsp_error_kind);
                  fail_count++;
               end
               if (rsp_addr_high !== e.addr_high) begin
                  $error("addr_high: expected %h, got %h", e.addr_high, rsp_addr_high);
                  fail_count++;
               end
               if (rsp_addr_low !== e.addr_low) begin
                  $error("addr_low: expected %h, got %h", e.addr_low, rsp_addr_low);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_char(req_char_code, req_last_char);
      end
      pending_count = expected_results.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the IP address text parser.
// ---------------------------------------------------------------------------
// Strings are streamed one character per request: a directed set of edge
// cases first, then random IPv4 and IPv6 addresses (some with an embedded
// IPv4 tail), many of them mutated, plus raw byte noise. The monitor module
// predicts and compares every response; this module only drives and judges.
// ---------------------------------------------------------------------------
module tb;
   import iatp_pkg::*;

   typedef byte unsigned text_type[$];

   localparam int CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_accepted;
   logic        rsp_is_v6;
   logic [1:0]  rsp_error_kind;
   logic [63:0] rsp_addr_high;
   logic [63:0] rsp_addr_low;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          chars_sent = 0;
   bit          random_phase = 1'b0;
   bit          steady_sender = 1'b0;

   always #5 clock = ~clock;

   ip_address_text_parser uut (.*);

   address_parse_monitor monitor (.*);

   // A hard stop in case the block hangs on either channel.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Receiver: after the first random string starts, it holds off for a long
   // stretch so that the response register fills and the input stalls.
   // Before that it is always ready; after it, random ready and not-ready runs alternate.
   initial begin
      int run;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (random_phase) break;
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
      rsp_ready <= 1'b0;
      for (int n = 0; n < 300; n++) @(posedge clock);
      forever begin
         run = pick_gap();
         if (run > 0) begin
            rsp_ready <= 1'b0;
            repeat (run) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         run = $urandom_range(1, 12);
         repeat (run) @(posedge clock);
      end
   end

   task automatic send_text(input text_type t);
      int gap;
      for (int i = 0; i < t.size(); i++) begin
         gap = steady_sender ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_char_code <= t[i];
         req_last_char <= (i == t.size() - 1);
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         chars_sent++;
      end
      req_valid <= 1'b0;
   endtask

   function automatic text_type to_text(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   task automatic add_decimal(ref text_type t, input int n);
      string s;
      s.itoa(n);
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
   endtask

   task automatic add_hex(ref text_type t, input int v, input int digits);
      int d;
      for (int i = digits - 1; i >= 0; i--) begin
         d = (v >> (4 * i)) & 15;
         if (d < 10) t.push_back(8'(8'h30 + d));
         else if ($urandom_range(0, 1)) t.push_back(8'(8'h61 + d - 10));
         else t.push_back(8'(8'h41 + d - 10));
      end
   endtask

   function automatic int pick_octet();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic add_quad(ref text_type t);
      for (int k = 0; k < 4; k++) begin
         if (k > 0) t.push_back(CharDot);
         add_decimal(t, pick_octet());
      end
   endtask

   task automatic add_group(ref text_type t);
      int digits;
      digits = $urandom_range(1, 4);
      add_hex(t, $urandom_range(0, 16'hFFFF), digits);
   endtask

   // Well-formed IPv6 text: optional gap anywhere, optional dotted tail.
   task automatic add_v6(ref text_type t);
      bit tail, gap;
      int slots, shown, left_n, right_n;
      tail = $urandom_range(0, 3) == 0;
      gap = $urandom_range(0, 1);
      slots = tail ? 6 : 8;
      shown = gap ? $urandom_range(0, slots - 1) : slots;
      left_n = gap ? $urandom_range(0, shown) : shown;
      right_n = shown - left_n;
      for (int k = 0; k < left_n; k++) begin
         if (k > 0) t.push_back(CharColon);
         add_group(t);
      end
      if (gap) begin
         t.push_back(CharColon);
         t.push_back(CharColon);
      end
      for (int k = 0; k < right_n; k++) begin
         if (k > 0) t.push_back(CharColon);
         add_group(t);
      end
      if (tail) begin
         if (right_n > 0 || (!gap && left_n > 0)) t.push_back(CharColon);
         add_quad(t);
      end
   endtask

   function automatic byte unsigned pick_char();
      string alphabet = ":.0912afAFgG";
      if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   // Breaks a string: replace, drop, repeat or insert one character.
   task automatic mutate(ref text_type t);
      int p;
      p = $urandom_range(0, t.size() - 1);
      case ($urandom_range(0, 3))
         0: t[p] = pick_char();
         1: if (t.size() > 1) t.delete(p);
         2: t.insert(p, t[p]);
         default: t.insert(p, pick_char());
      endcase
   endtask

   initial begin
      string directed [$] = '{
         "1.2.3.4", "255.255.255.255", "0.0.0.0", "256.1.1.1", "01.1.1.1",
         "1234.1.1.1", "1.2.3", "1.2.3.4.5", "::", "::1", "1::",
         "1:2:3:4:5:6:7:8", "1:2:3:4:5:6:7:8:", "1:2:3:4:5:6:7::8",
         "ffff:FFFF:abcd:ABCD:0:1:2:3", "12345::", "::ffff:1.2.3.4",
         "1:2:3:4:5:6:1.2.3.4", "1:2:3:4:5:6:7:1.2.3.4", "1.2.3.4::",
         "1::2::3", ":1", "x", "7", "::01.2.3.4"};
      text_type t;
      int p;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_text(to_text(directed[i]));
      // A character that is not ASCII at all.
      t = to_text("1.2.3.4");
      t[2] = 8'hC8;
      send_text(t);

      random_phase = 1'b1;
      while (chars_sent < 1300) begin
         steady_sender = $urandom_range(0, 4) == 0;
         t.delete();
         p = $urandom_range(0, 99);
         if (p < 35) add_quad(t);
         else if (p < 80) add_v6(t);
         else begin
            repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(0, 255)));
         end
         if (p < 80 && $urandom_range(0, 2) == 0) mutate(t);
         send_text(t);
      end

      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
